>>> rtl/fcbm_pkg.sv
// ----------------------------------------------------------------------------
// FAT chain block manager package
// Shared payload types, request and status codes, and the command and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package fcbm_pkg;

   // Default sizing of the table and the root directory.
   localparam int DEF_NUM_BLOCKS   = 256;
   localparam int DEF_ROOT_SLOTS   = 16;
   localparam int DEF_TABLE_BLOCKS = 4;

   // Request codes. Codes above REQ_FIRST are unknown requests.
   typedef enum logic [2:0] {
      REQ_CREATE = 3'd0,
      REQ_ADD    = 3'd1,
      REQ_DELETE = 3'd2,
      REQ_CHECK  = 3'd3,
      REQ_NEXT   = 3'd4,
      REQ_FIRST  = 3'd5
   } req_code_type;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_NOFREE = 3'd1,
      ST_NOFILE = 3'd2,
      ST_NOTIN  = 3'd3,
      ST_EXISTS = 3'd4
   } status_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic [3:0] file_slot;
      logic [7:0] block_num;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] block_out;
      logic       is_member;
   } rsp_payload_type;

   // Table read address source.
   typedef enum logic [1:0] {
      RD_HEAD  = 2'd0,
      RD_FIRST = 2'd1,
      RD_LINK  = 2'd2
   } rd_sel_type;

   // Table write address source.
   typedef enum logic [1:0] {
      WA_HEAD = 2'd0,
      WA_CUR  = 2'd1,
      WA_PREV = 2'd2
   } wr_addr_sel_type;

   // Table write data source.
   typedef enum logic [1:0] {
      WD_ZERO = 2'd0,
      WD_HEAD = 2'd1,
      WD_NXT  = 2'd2
   } wr_data_sel_type;

   // Source of the result block number.
   typedef enum logic [1:0] {
      BO_ZERO  = 2'd0,
      BO_FIRST = 2'd1,
      BO_LINK  = 2'd2,
      BO_HEAD  = 2'd3
   } bout_sel_type;

   // Source of a new first block or a new free-list head.
   typedef enum logic {
      SRC_A = 1'b0,
      SRC_B = 1'b1
   } src_sel_type;

   typedef struct packed {
      logic            load_req;
      logic            init_step;
      logic            rd_en;
      rd_sel_type      rd_sel;
      logic            mem_wr;
      wr_addr_sel_type wr_addr_sel;
      wr_data_sel_type wr_data_sel;
      logic            walk_start;
      logic            walk_step;
      logic            save_nxt;
      logic            dir_create;
      logic            dir_first_wr;
      src_sel_type     dir_first_sel;  // SRC_A: free head, SRC_B: saved link
      logic            head_wr;
      src_sel_type     head_sel;       // SRC_A: saved link, SRC_B: current block
      logic            res_set;
      status_type      res_status;
      bout_sel_type    res_bout_sel;
      logic            res_member;
      logic            out_load;
   } cmd_type;

   typedef struct packed {
      logic [2:0] req_kind;
      logic       slot_ok;
      logic       slot_used;
      logic       head_zero;
      logic       first_zero;
      logic       cur_is_blk;
      logic       link_zero;
      logic       prev_zero;
      logic       cnt_last;
      logic       init_last;
   } sts_type;

endpackage

>>> rtl/fcbm_dpath.sv
// ----------------------------------------------------------------------------
// FAT chain block manager datapath
// Holds the link table memory, the root directory, the free-list head, the
// chain walk registers and the result and output registers.
// ----------------------------------------------------------------------------
module fcbm_dpath #(
   parameter int NUM_BLOCKS   = fcbm_pkg::DEF_NUM_BLOCKS,
   parameter int ROOT_SLOTS   = fcbm_pkg::DEF_ROOT_SLOTS,
   parameter int TABLE_BLOCKS = fcbm_pkg::DEF_TABLE_BLOCKS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  fcbm_pkg::req_payload_type req_data,
   input  fcbm_pkg::cmd_type         cmd,
   output fcbm_pkg::sts_type         sts,
   output fcbm_pkg::rsp_payload_type rsp_data
);
   import fcbm_pkg::*;

   localparam int BW = $clog2(NUM_BLOCKS);
   localparam int SW = (ROOT_SLOTS > 1) ? $clog2(ROOT_SLOTS) : 1;
   localparam int DATA_FIRST = TABLE_BLOCKS + 2;
   localparam logic [BW-1:0] LAST_BLK = BW'(NUM_BLOCKS - 1);
   localparam logic [BW-1:0] HEAD_RESET =
      (DATA_FIRST < NUM_BLOCKS) ? BW'(DATA_FIRST) : '0;

   logic [BW-1:0]   link_mem [NUM_BLOCKS];
   logic [BW-1:0]   rdata_ff;

   req_payload_type req_ff;
   logic [BW-1:0]   head_ff;
   logic [BW-1:0]   cur_ff;
   logic [BW-1:0]   prev_ff;
   logic [BW-1:0]   cnt_ff;
   logic [BW-1:0]   nxt_ff;
   logic [BW-1:0]   init_cnt_ff;
   logic [ROOT_SLOTS-1:0] used_ff;
   logic [BW-1:0]   first_ff [ROOT_SLOTS];
   logic [2:0]      res_status_ff;
   logic [7:0]      res_bout_ff;
   logic            res_member_ff;
   rsp_payload_type rsp_ff;

   logic [SW-1:0]   slot_idx;
   logic [BW-1:0]   blk_idx;
   logic            blk_ok;
   logic [BW-1:0]   first_blk;
   logic [BW-1:0]   rd_addr;
   logic            wr_en;
   logic [BW-1:0]   wr_addr;
   logic [BW-1:0]   wr_data;
   logic [BW-1:0]   init_val;
   logic [BW-1:0]   bout_val;

   assign slot_idx  = SW'(req_ff.file_slot);
   assign blk_idx   = BW'(req_ff.block_num);
   assign blk_ok    = 32'(req_ff.block_num) < 32'(NUM_BLOCKS);
   assign first_blk = first_ff[slot_idx];

   // Reset image of the table: data blocks chained in order, the rest zero.
   always_comb begin
      if ((32'(init_cnt_ff) >= 32'(DATA_FIRST)) && (init_cnt_ff != LAST_BLK)) begin
         init_val = init_cnt_ff + BW'(1);
      end else begin
         init_val = '0;
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_HEAD:  rd_addr = head_ff;
         RD_FIRST: rd_addr = first_blk;
         RD_LINK:  rd_addr = rdata_ff;
         default:  rd_addr = rdata_ff;
      endcase
   end

   always_comb begin
      wr_en = cmd.init_step | cmd.mem_wr;
      if (cmd.init_step) begin
         wr_addr = init_cnt_ff;
         wr_data = init_val;
      end else begin
         case (cmd.wr_addr_sel)
            WA_HEAD: wr_addr = head_ff;
            WA_CUR:  wr_addr = cur_ff;
            WA_PREV: wr_addr = prev_ff;
            default: wr_addr = cur_ff;
         endcase
         case (cmd.wr_data_sel)
            WD_ZERO: wr_data = '0;
            WD_HEAD: wr_data = head_ff;
            WD_NXT:  wr_data = nxt_ff;
            default: wr_data = '0;
         endcase
      end
   end

   always_comb begin
      case (cmd.res_bout_sel)
         BO_ZERO:  bout_val = '0;
         BO_FIRST: bout_val = first_blk;
         BO_LINK:  bout_val = rdata_ff;
         BO_HEAD:  bout_val = head_ff;
         default:  bout_val = '0;
      endcase
   end

   // Link table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= link_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= HEAD_RESET;
         used_ff     <= '0;
         init_cnt_ff <= '0;
      end else begin
         if (cmd.init_step) begin
            init_cnt_ff <= init_cnt_ff + BW'(1);
         end
         if (cmd.dir_create) begin
            used_ff[slot_idx] <= 1'b1;
         end
         if (cmd.head_wr) begin
            head_ff <= (cmd.head_sel == SRC_B) ? cur_ff : nxt_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.dir_create) begin
         first_ff[slot_idx] <= '0;
      end else if (cmd.dir_first_wr) begin
         first_ff[slot_idx] <= (cmd.dir_first_sel == SRC_B) ? nxt_ff : head_ff;
      end
      if (cmd.walk_start) begin
         cur_ff  <= first_blk;
         prev_ff <= '0;
         cnt_ff  <= '0;
      end else if (cmd.walk_step) begin
         cur_ff  <= rdata_ff;
         prev_ff <= cur_ff;
         cnt_ff  <= cnt_ff + BW'(1);
      end
      if (cmd.save_nxt) begin
         nxt_ff <= rdata_ff;
      end
      if (cmd.res_set) begin
         res_status_ff <= cmd.res_status;
         res_bout_ff   <= 8'(bout_val);
         res_member_ff <= cmd.res_member;
      end
      if (cmd.out_load) begin
         rsp_ff.status    <= res_status_ff;
         rsp_ff.block_out <= res_bout_ff;
         rsp_ff.is_member <= res_member_ff;
      end
   end

   assign rsp_data = rsp_ff;

   assign sts.req_kind   = req_ff.req_type;
   assign sts.slot_ok    = 32'(req_ff.file_slot) < 32'(ROOT_SLOTS);
   assign sts.slot_used  = used_ff[slot_idx];
   assign sts.head_zero  = (head_ff == '0);
   assign sts.first_zero = (first_blk == '0);
   assign sts.cur_is_blk = blk_ok && (cur_ff == blk_idx);
   assign sts.link_zero  = (rdata_ff == '0);
   assign sts.prev_zero  = (prev_ff == '0);
   assign sts.cnt_last   = (cnt_ff == LAST_BLK);
   assign sts.init_last  = (init_cnt_ff == LAST_BLK);

endmodule

>>> rtl/fcbm_ctrl.sv
// ----------------------------------------------------------------------------
// FAT chain block manager controller
// Sequences table initialization, request decode, chain walks, table and
// directory updates, and the output handshake.
// ----------------------------------------------------------------------------
module fcbm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  fcbm_pkg::sts_type sts,
   output fcbm_pkg::cmd_type cmd
);
   import fcbm_pkg::*;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_DECODE,
      S_ADD_HEAD,
      S_WALK,
      S_ADD_FIN,
      S_DEL_LINK,
      S_DEL_PUSH
   } state_type;

   // A separate flag marks a result waiting to move into the output register.
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      pend_ff, pend_in;
   logic      out_free;

   assign req_ready = (state_ff == S_IDLE) && !pend_ff;
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      pend_in  = pend_ff;

      // Move a finished result into the output register when it is free.
      if (pend_ff && out_free) begin
         cmd.out_load = 1'b1;
         pend_in      = 1'b0;
      end
      rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

      unique case (state_ff)
         S_INIT: begin
            cmd.init_step = 1'b1;
            if (sts.init_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.res_set = 1'b1;
            state_in    = S_IDLE;
            if (sts.req_kind > REQ_FIRST) begin
               cmd.res_status = ST_OK;
            end else if ((sts.req_kind == REQ_ADD) && sts.head_zero) begin
               cmd.res_status = ST_NOFREE;
            end else if (!sts.slot_ok) begin
               cmd.res_status = ST_NOFILE;
            end else if (sts.req_kind == REQ_CREATE) begin
               if (sts.slot_used) begin
                  cmd.res_status = ST_EXISTS;
               end else begin
                  cmd.res_status = ST_OK;
                  cmd.dir_create = 1'b1;
               end
            end else if (!sts.slot_used) begin
               cmd.res_status = ST_NOFILE;
            end else if (sts.req_kind == REQ_FIRST) begin
               cmd.res_status   = ST_OK;
               cmd.res_bout_sel = BO_FIRST;
            end else if (sts.req_kind == REQ_ADD) begin
               cmd.res_set = 1'b0;
               cmd.rd_en   = 1'b1;
               cmd.rd_sel  = RD_HEAD;
               state_in    = S_ADD_HEAD;
            end else if (sts.first_zero) begin
               // Empty file: nothing can be a member.
               cmd.res_status = (sts.req_kind == REQ_CHECK) ? ST_OK : ST_NOTIN;
            end else begin
               cmd.res_set    = 1'b0;
               cmd.walk_start = 1'b1;
               cmd.rd_en      = 1'b1;
               cmd.rd_sel     = RD_FIRST;
               state_in       = S_WALK;
            end
            if (state_in == S_IDLE) begin
               pend_in = 1'b1;
            end
         end
         S_ADD_HEAD: begin
            // The link of the allocated block becomes the new free head.
            cmd.save_nxt    = 1'b1;
            cmd.mem_wr      = 1'b1;
            cmd.wr_addr_sel = WA_HEAD;
            cmd.wr_data_sel = WD_ZERO;
            if (sts.first_zero) begin
               state_in = S_ADD_FIN;
            end else begin
               cmd.walk_start = 1'b1;
               cmd.rd_en      = 1'b1;
               cmd.rd_sel     = RD_FIRST;
               state_in       = S_WALK;
            end
         end
         S_WALK: begin
            if (sts.req_kind == REQ_ADD) begin
               if (sts.link_zero || sts.cnt_last) begin
                  cmd.mem_wr      = 1'b1;
                  cmd.wr_addr_sel = WA_CUR;
                  cmd.wr_data_sel = WD_HEAD;
                  state_in        = S_ADD_FIN;
               end else begin
                  cmd.walk_step = 1'b1;
                  cmd.rd_en     = 1'b1;
                  cmd.rd_sel    = RD_LINK;
               end
            end else if (sts.cur_is_blk) begin
               if (sts.req_kind == REQ_DELETE) begin
                  cmd.save_nxt = 1'b1;
                  state_in     = S_DEL_LINK;
               end else begin
                  cmd.res_set      = 1'b1;
                  cmd.res_status   = ST_OK;
                  cmd.res_member   = (sts.req_kind == REQ_CHECK);
                  cmd.res_bout_sel = (sts.req_kind == REQ_NEXT) ? BO_LINK : BO_ZERO;
                  pend_in          = 1'b1;
                  state_in         = S_IDLE;
               end
            end else if (sts.link_zero || sts.cnt_last) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = (sts.req_kind == REQ_CHECK) ? ST_OK : ST_NOTIN;
               pend_in        = 1'b1;
               state_in       = S_IDLE;
            end else begin
               cmd.walk_step = 1'b1;
               cmd.rd_en     = 1'b1;
               cmd.rd_sel    = RD_LINK;
            end
         end
         S_ADD_FIN: begin
            cmd.dir_first_wr  = sts.first_zero;
            cmd.dir_first_sel = SRC_A;
            cmd.res_set       = 1'b1;
            cmd.res_status    = ST_OK;
            cmd.res_bout_sel  = BO_HEAD;
            cmd.head_wr       = 1'b1;
            cmd.head_sel      = SRC_A;
            pend_in           = 1'b1;
            state_in          = S_IDLE;
         end
         S_DEL_LINK: begin
            // Bridge the chain around the deleted block.
            if (sts.prev_zero) begin
               cmd.dir_first_wr  = 1'b1;
               cmd.dir_first_sel = SRC_B;
            end else begin
               cmd.mem_wr      = 1'b1;
               cmd.wr_addr_sel = WA_PREV;
               cmd.wr_data_sel = WD_NXT;
            end
            state_in = S_DEL_PUSH;
         end
         S_DEL_PUSH: begin
            cmd.mem_wr      = 1'b1;
            cmd.wr_addr_sel = WA_CUR;
            cmd.wr_data_sel = WD_HEAD;
            cmd.head_wr     = 1'b1;
            cmd.head_sel    = SRC_B;
            cmd.res_set     = 1'b1;
            cmd.res_status  = ST_OK;
            pend_in         = 1'b1;
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

endmodule

>>> rtl/fat_chain_block_manager.sv
// ----------------------------------------------------------------------------
// FAT chain block manager
// Create, first block and unknown requests are settled in the decode state;
// add, delete, check and next on a file with blocks walk its chain one link
// per cycle through the single table read port. Each result is moved into
// the output register once it is free. One request is in work at a time.
// Reset: a pass over the whole table writes the free chain with req_ready low.
// ----------------------------------------------------------------------------
module fat_chain_block_manager #(
   parameter int NUM_BLOCKS   = fcbm_pkg::DEF_NUM_BLOCKS,
   parameter int ROOT_SLOTS   = fcbm_pkg::DEF_ROOT_SLOTS,
   parameter int TABLE_BLOCKS = fcbm_pkg::DEF_TABLE_BLOCKS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  fcbm_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output fcbm_pkg::rsp_payload_type rsp_data
);
   import fcbm_pkg::*;

   // The controller only issues commands; every piece of state that the
   // requests touch (the link table, the directory, the free-list head and
   // the walk pointers) lives in the datapath.
   cmd_type cmd;
   sts_type sts;

   // Controller: reset starts it in the table initialization pass. It then
   // decodes each request beat, walks chains one link per cycle from the
   // registered table read data, and finishes with at most two table writes
   // for add and delete. A finished result waits in the output register
   // while the next beat is taken.
   fcbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: entry 0 of the table, the free-list head, is held in a
   // register; after the initialization pass the memory sees only data blocks.
   fcbm_dpath #(
      .NUM_BLOCKS   (NUM_BLOCKS),
      .ROOT_SLOTS   (ROOT_SLOTS),
      .TABLE_BLOCKS (TABLE_BLOCKS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

>>> test/fcbm_reply_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT chain block manager reply checker
// Watches both channels of the block. It keeps its own copy of the link
// table and the root directory, works out the reply to every accepted
// request, and compares each accepted reply with the oldest one still owed.
// ----------------------------------------------------------------------------
module fcbm_reply_checker #(
   parameter int NUM_BLOCKS   = fcbm_pkg::DEF_NUM_BLOCKS,
   parameter int ROOT_SLOTS   = fcbm_pkg::DEF_ROOT_SLOTS,
   parameter int TABLE_BLOCKS = fcbm_pkg::DEF_TABLE_BLOCKS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  fcbm_pkg::req_payload_type req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  fcbm_pkg::rsp_payload_type rsp_data,
   output int                        mismatch_count,
   output int                        replies_owed
);
   import fcbm_pkg::*;

   localparam int FIRST_DATA = TABLE_BLOCKS + 2;

   logic [7:0]      fat_link   [NUM_BLOCKS];
   logic            slot_open  [ROOT_SLOTS];
   logic [7:0]      slot_start [ROOT_SLOTS];
   rsp_payload_type expected_replies [$];
   int              errors = 0;

   // Walks the chain of a slot, bounded by the table size.
   function automatic logic chain_holds(int slot, logic [7:0] blk);
      logic [7:0] cur;
      int         n;
      cur = slot_start[slot];
      for (n = 0; cur != '0 && n < NUM_BLOCKS; n++) begin
         if (cur == blk) return 1'b1;
         cur = fat_link[cur];
      end
      return 1'b0;
   endfunction

   // Applies one request to the shadow state and returns its reply.
   function automatic rsp_payload_type predict_reply(req_payload_type beat);
      rsp_payload_type reply;
      logic [7:0]      blk;
      logic [7:0]      alloc;
      logic [7:0]      b;
      int              slot;
      int              n;
      reply        = '0;
      reply.status = ST_OK;
      slot         = int'(beat.file_slot);
      blk          = beat.block_num;
      if (beat.req_type > REQ_FIRST) begin
         // Unknown codes leave everything alone.
      end else if (beat.req_type == REQ_ADD && fat_link[0] == '0) begin
         reply.status = ST_NOFREE;
      end else if (slot >= ROOT_SLOTS) begin
         reply.status = ST_NOFILE;
      end else if (beat.req_type == REQ_CREATE) begin
         if (slot_open[slot]) begin
            reply.status = ST_EXISTS;
         end else begin
            slot_open[slot]  = 1'b1;
            slot_start[slot] = '0;
         end
      end else if (!slot_open[slot]) begin
         reply.status = ST_NOFILE;
      end else begin
         case (beat.req_type)
            REQ_ADD: begin
               alloc           = fat_link[0];
               fat_link[0]     = fat_link[alloc];
               fat_link[alloc] = '0;
               b               = slot_start[slot];
               if (b == '0) begin
                  slot_start[slot] = alloc;
               end else begin
                  for (n = 0; fat_link[b] != '0 && n < NUM_BLOCKS; n++) b = fat_link[b];
                  fat_link[b] = alloc;
               end
               reply.block_out = alloc;
            end
            REQ_DELETE: begin
               if (!chain_holds(slot, blk)) begin
                  reply.status = ST_NOTIN;
               end else begin
                  b = slot_start[slot];
                  if (b == blk) begin
                     slot_start[slot] = fat_link[blk];
                  end else begin
                     for (n = 0; fat_link[b] != blk && n < NUM_BLOCKS; n++) b = fat_link[b];
                     fat_link[b] = fat_link[blk];
                  end
                  fat_link[blk] = fat_link[0];
                  fat_link[0]   = blk;
               end
            end
            REQ_CHECK: begin
               reply.is_member = chain_holds(slot, blk);
            end
            REQ_NEXT: begin
               if (chain_holds(slot, blk)) reply.block_out = fat_link[blk];
               else reply.status = ST_NOTIN;
            end
            default: begin
               reply.block_out = slot_start[slot];
            end
         endcase
      end
      return reply;
   endfunction

   always @(posedge clock) begin : reply_watch
      int              i;
      rsp_payload_type want;
      if (reset) begin
         for (i = 0; i < NUM_BLOCKS; i++) fat_link[i] = '0;
         for (i = 0; i < ROOT_SLOTS; i++) begin
            slot_open[i]  = 1'b0;
            slot_start[i] = '0;
         end
         if (FIRST_DATA < NUM_BLOCKS) begin
            fat_link[0] = 8'(FIRST_DATA);
            for (i = FIRST_DATA; i + 1 < NUM_BLOCKS; i++) fat_link[i] = 8'(i + 1);
            fat_link[NUM_BLOCKS-1] = '0;
         end
         expected_replies.delete();
      end else begin
         // The reply side goes first so that a stray reply can never take
         // the expectation of a request accepted at the same edge.
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               errors++;
               $display("%0t: reply beat with none owed, got status %0d block %0d member %0b",
                        $time, rsp_data.status, rsp_data.block_out, rsp_data.is_member);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_data.status !== want.status) begin
                  errors++;
                  $display("%0t: status expected %0d, got %0d",
                           $time, want.status, rsp_data.status);
               end
               if (rsp_data.block_out !== want.block_out) begin
                  errors++;
                  $display("%0t: block_out expected %0d, got %0d",
                           $time, want.block_out, rsp_data.block_out);
               end
               if (rsp_data.is_member !== want.is_member) begin
                  errors++;
                  $display("%0t: is_member expected %0b, got %0b",
                           $time, want.is_member, rsp_data.is_member);
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_replies.insert(expected_replies.size(), predict_reply(req_data));
         end
      end
      mismatch_count <= errors;
      replies_owed   <= expected_replies.size();
   end

endmodule

>>> test/fat_chain_block_manager_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT chain block manager testbench
// Sends a short directed sequence, a run that drains the free list, and a
// long stream of mostly well-formed random requests, with random idle gaps
// on both channels. A separate checker predicts and compares every reply.
// ----------------------------------------------------------------------------
module fat_chain_block_manager_tb;
   import fcbm_pkg::*;

   localparam int CLOCK_PERIOD    = 4;
   localparam int RESET_CYCLES    = 10;
   localparam int FIRST_DATA      = DEF_TABLE_BLOCKS + 2;
   localparam int FILL_BEATS      = 252;
   localparam int RANDOM_BEATS    = 1470;
   localparam int IDLE_MAX        = 11;
   localparam int HOLD_OFF_AFTER  = 700;
   localparam int HOLD_OFF_CYCLES = 900;
   localparam int PAUSE_AT        = 1200;
   localparam int STALL_LIMIT     = 5000;
   localparam int DRAIN_CYCLES    = DEF_NUM_BLOCKS + 16;

   // The two request codes that the block does not know.
   localparam logic [2:0] REQ_UNKNOWN_LO = 3'd6;
   localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;

   // A block that a reply named as part of a file, kept so that later
   // delete, check and next requests hit real chain members.
   typedef struct {
      logic [3:0] slot;
      logic [7:0] blk;
   } owned_block_type;

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_data;
   int              mismatch_count;
   int              replies_owed;

   // Requests in the order the block accepted them, so that the reply side
   // can tell which request each reply belongs to.
   req_payload_type sent_requests [$];
   owned_block_type owned_blocks [$];
   int              stall_cycles = 0;
   bit              send_calm;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   fat_chain_block_manager i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   fcbm_reply_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .replies_owed   (replies_owed)
   );

   function automatic req_payload_type make_req(logic [2:0] code, int slot, int blk);
      req_payload_type beat;
      beat.req_type  = code;
      beat.file_slot = 4'(slot);
      beat.block_num = 8'(blk);
      return beat;
   endfunction

   // Builds one random request. Most requests go to a handful of slots so
   // that their files grow long chains, and most delete, check and next block
   // operands come from blocks that earlier replies tied to a file.
   function automatic req_payload_type random_request();
      req_payload_type beat;
      int              pick;
      int              idx;
      bit              use_owned;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 80) beat.file_slot = 4'($urandom_range(0, 3));
      else beat.file_slot = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 99) < 60) beat.block_num = 8'($urandom_range(FIRST_DATA, 255));
      else beat.block_num = 8'($urandom_range(0, 255));
      use_owned = owned_blocks.size() != 0 && $urandom_range(0, 99) < 70;
      idx       = use_owned ? $urandom_range(0, owned_blocks.size() - 1) : 0;
      if (pick < 25)      beat.req_type = REQ_ADD;
      else if (pick < 50) beat.req_type = REQ_DELETE;
      else if (pick < 66) beat.req_type = REQ_CHECK;
      else if (pick < 80) beat.req_type = REQ_NEXT;
      else if (pick < 86) beat.req_type = REQ_FIRST;
      else if (pick < 92) beat.req_type = REQ_CREATE;
      else if (pick < 94) beat.req_type = REQ_UNKNOWN_LO;
      else if (pick < 96) beat.req_type = REQ_UNKNOWN_HI;
      else beat = req_payload_type'(15'($urandom));
      if (use_owned && (beat.req_type == REQ_DELETE || beat.req_type == REQ_CHECK ||
                        beat.req_type == REQ_NEXT)) begin
         beat.file_slot = owned_blocks[idx].slot;
         beat.block_num = owned_blocks[idx].blk;
         // A deleted block goes back to the free list, so it is forgotten.
         if (beat.req_type == REQ_DELETE) owned_blocks.delete(idx);
      end
      return beat;
   endfunction

   // Offers one request beat after a random gap and returns at the edge
   // that accepts it. Valid is only lowered when a gap follows, so a beat
   // sent back to back keeps valid high without a second assignment.
   task automatic send_request(input req_payload_type beat);
      int gap;
      if ($urandom_range(0, 99) < 3) send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, IDLE_MAX);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      // Ready is sampled half a cycle away from the edge at which it moves.
      do @(negedge clock); while (!req_ready);
      sent_requests.insert(sent_requests.size(), beat);
      @(posedge clock);
   endtask

   // Stops offering requests until every owed reply has been taken. The
   // extra edge lets the count pick up the beat accepted just now.
   task automatic wait_all_replies();
      req_valid <= 1'b0;
      @(posedge clock);
      while (replies_owed != 0) @(posedge clock);
   endtask

   // Request side: reset, then directed cases, a free-list drain, and the
   // random stream, and finally the verdict.
   initial begin : request_source
      int n;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      send_calm  = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Requests on a slot that was never created, with free blocks left.
      send_request(make_req(REQ_FIRST, 0, 0));
      send_request(make_req(REQ_ADD, 0, 0));
      send_request(make_req(REQ_CHECK, 15, 255));
      // Create, then create again on the slot that is now in use.
      send_request(make_req(REQ_CREATE, 0, 0));
      send_request(make_req(REQ_CREATE, 0, 0));
      // An empty file has no first block and no members.
      send_request(make_req(REQ_FIRST, 0, 0));
      send_request(make_req(REQ_NEXT, 0, 0));
      // Grow a three-block chain.
      send_request(make_req(REQ_ADD, 0, 0));
      send_request(make_req(REQ_ADD, 0, 0));
      send_request(make_req(REQ_ADD, 0, 0));
      // Membership of a real member, block zero, a reserved block and the
      // top block number.
      send_request(make_req(REQ_CHECK, 0, FIRST_DATA));
      send_request(make_req(REQ_CHECK, 0, 0));
      send_request(make_req(REQ_CHECK, 0, FIRST_DATA - 1));
      send_request(make_req(REQ_CHECK, 0, 255));
      // Next of the head, next of the tail, next of a stranger.
      send_request(make_req(REQ_NEXT, 0, FIRST_DATA));
      send_request(make_req(REQ_NEXT, 0, FIRST_DATA + 2));
      send_request(make_req(REQ_NEXT, 0, 100));
      // Unlink from the middle, then from the head, then a non-member, then
      // a delete on an unused slot.
      send_request(make_req(REQ_DELETE, 0, FIRST_DATA + 1));
      send_request(make_req(REQ_DELETE, 0, FIRST_DATA));
      send_request(make_req(REQ_DELETE, 0, 200));
      send_request(make_req(REQ_DELETE, 3, FIRST_DATA));
      // Both unknown codes, with the field extremes.
      send_request(make_req(REQ_UNKNOWN_LO, 15, 255));
      send_request(make_req(REQ_UNKNOWN_HI, 0, 0));
      // The top slot.
      send_request(make_req(REQ_CREATE, 15, 0));
      send_request(make_req(REQ_ADD, 15, 0));
      send_request(make_req(REQ_FIRST, 15, 0));

      // The sender sits idle here until the block has answered everything.
      wait_all_replies();

      // Append to the two open files until the free list runs dry; the
      // last few adds find no free block.
      for (n = 0; n < FILL_BEATS; n++) begin
         send_request(make_req(REQ_ADD, $urandom_range(0, 1) ? 0 : 15, $urandom_range(0, 255)));
      end
      // With the free list empty, an add on an unused slot still reports
      // the missing free block rather than the missing file.
      send_request(make_req(REQ_ADD, 5, 0));

      for (n = 0; n < RANDOM_BEATS; n++) begin
         if (n == PAUSE_AT) wait_all_replies();
         send_request(random_request());
      end

      wait_all_replies();
      // Nothing is owed any more; give a stray reply time to show up.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && replies_owed == 0) begin
         $display("[fat_chain_block_manager] OK");
      end else begin
         $display("[fat_chain_block_manager] ERROR");
      end
      $finish;
   end

   // Reply side: random ready gaps, one long hold-off that lets the block
   // fill up and stall its input, and collection of blocks that replies
   // name as part of a file.
   initial begin : reply_sink
      int              gap;
      int              taken;
      bit              calm;
      req_payload_type beat;
      owned_block_type entry;
      taken = 0;
      calm  = 1'b0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken == HOLD_OFF_AFTER) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         if ($urandom_range(0, 99) < 3) calm = !calm;
         gap = calm ? 0 : $urandom_range(0, IDLE_MAX);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(negedge clock); while (!rsp_valid);
         if (sent_requests.size() != 0) begin
            beat = sent_requests.pop_front();
            // Add, next and first replies name a block of the file.
            if (rsp_data.status == ST_OK && rsp_data.block_out != '0 &&
                (beat.req_type == REQ_ADD || beat.req_type == REQ_NEXT ||
                 beat.req_type == REQ_FIRST)) begin
               entry.slot = beat.file_slot;
               entry.blk  = rsp_data.block_out;
               if (owned_blocks.size() < 96) owned_blocks.insert(owned_blocks.size(), entry);
               else owned_blocks[$urandom_range(0, 95)] = entry;
            end
         end
         taken++;
         @(posedge clock);
      end
   end

   // Watchdog: ends the run when no beat moves on either channel for too
   // long. The limit covers the longest chain walk, the idle gaps, the
   // reply hold-off and the table initialization pass after reset.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("[fat_chain_block_manager] ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule

>>> files.f
rtl/fcbm_pkg.sv
rtl/fcbm_dpath.sv
rtl/fcbm_ctrl.sv
rtl/fat_chain_block_manager.sv
test/fcbm_reply_checker.sv
test/fat_chain_block_manager_tb.sv
